// ===== design/red_pkg.sv =====
`timescale 1ns / 1ps

package red_pkg;

	localparam int PENDING_WIDTH_DEF = 16;

	localparam int DIV_W = 17;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int DELTA_W = 18;
	localparam int REM_W = 9;

	localparam logic [16:0] MODULUS_RESET = 17'd81;
	localparam logic [7:0] CPD_RESET = 8'd4;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd80;

	localparam int POP_DET_MAX = 127;
	localparam int POP_DET_MIN = -128;
	localparam int POP_PRESS_MAX = 255;

	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_CPD = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE = 2'd2;

	typedef enum logic [2:0] {
		CMD_POLL = 3'd0,
		CMD_POP_DETENTS = 3'd1,
		CMD_POP_PRESSES = 3'd2,
		CMD_PUSH_BACK = 3'd3,
		CMD_INIT = 3'd4
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WRAP,
		ST_SUM,
		ST_START,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} red_state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== design/red_intf.sv =====
`timescale 1ns / 1ps

interface red_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [15:0] encoder_count;
	logic [31:0] switch_edge_count;
	logic [31:0] now_ticks;
	logic [7:0] pushback_amount;

	modport source (output valid, command, encoder_count, switch_edge_count, now_ticks,
		pushback_amount, input ready);
	modport sink (input valid, command, encoder_count, switch_edge_count, now_ticks,
		pushback_amount, output ready);
endinterface

interface red_res_if;
	logic valid;
	logic ready;
	logic signed [7:0] detent_delta;
	logic [7:0] press_count;

	modport source (output valid, detent_delta, press_count, input ready);
	modport sink (input valid, detent_delta, press_count, output ready);
endinterface

interface red_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/red_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module red_div import red_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_ctl_t ctl,
	input logic [DIV_W-1:0] dividend,
	input logic [7:0] divisor,
	output div_sts_t sts,
	output logic [DIV_W-1:0] quotient,
	output logic [7:0] remainder
);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [7:0] rem_q;

	logic [8:0] trial;
	logic [8:0] diff;
	logic fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff = trial - {1'b0, divisor};
		fits = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[7:0] : trial[7:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < divisor)
		else $error("divider remainder not below divisor");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a preceding busy cycle");

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q)
		else $error("divider did not go busy after a start");

endmodule

// ===== design/rotary_encoder_detent_and_press_events.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// cmd       in         command, encoder_count, switch_edge_count, now_ticks, pushback_amount
// res       out        detent_delta, press_count
// cfg       in         index, data (write only, always ready)
//
// A poll runs the wrap, sum, the 17 steps of the serial divider by counts per
// detent and the apply step; all other commands, and a poll before the block is
// initialised, go straight to the result. One request is in work at a time;
// cmd.ready is high only when idle, entered as the result is posted once the output is free.
// A finished result waits in the output register while the next request is taken.
// Reset clears all pending counts and the configuration to its defaults.
module rotary_encoder_detent_and_press_events import red_pkg::*; #(
	parameter int PENDING_WIDTH = PENDING_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	red_cmd_if.sink cmd,
	red_res_if.source res,
	red_cfg_if.sink cfg
);

	localparam int PW = PENDING_WIDTH;
	localparam int AW = ((PW > DELTA_W) ? PW : DELTA_W) + 1;
	localparam logic signed [PW-1:0] DET_SAT_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] DET_SAT_MIN = {1'b1, {(PW-1){1'b0}}};
	localparam logic [PW-1:0] PRESS_SAT_MAX = {PW{1'b1}};
	localparam logic signed [PW-1:0] DET_POP_HI = PW'(POP_DET_MAX);
	localparam logic signed [PW-1:0] DET_POP_LO = PW'(POP_DET_MIN);
	localparam logic [PW-1:0] PRESS_POP_MAX = PW'(POP_PRESS_MAX);

	red_state_t state_q, state_d;

	logic [16:0] cfg_mod_q;
	logic [7:0] cfg_cpd_q;
	logic [15:0] cfg_deb_q;

	logic init_q;
	logic [15:0] last_enc_q;
	logic signed [REM_W-1:0] rem_q;
	logic signed [PW-1:0] det_q;
	logic [31:0] last_sw_q;
	logic [PW-1:0] pr_q;
	logic [31:0] last_tick_q;

	logic [2:0] cmd_q;
	logic [15:0] enc_q;
	logic [31:0] sw_q;
	logic [31:0] now_q;
	logic [7:0] back_q;
	logic signed [DELTA_W-1:0] dlt_q;
	logic signed [DELTA_W-1:0] sum_q;
	logic signed [7:0] res_det_q;
	logic [7:0] res_pr_q;

	logic out_valid_q;
	logic signed [7:0] out_det_q;
	logic [7:0] out_pr_q;

	div_ctl_t div_ctl;
	div_sts_t div_sts;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_quo;
	logic [7:0] div_rem;
	logic [7:0] cpd_eff;

	logic cmd_take;
	logic out_free;

	logic signed [DELTA_W-1:0] raw_delta;
	logic signed [DELTA_W-1:0] mod_s;
	logic signed [DELTA_W-1:0] half_s;
	logic signed [DELTA_W-1:0] wrapped;
	logic [31:0] elapsed;
	logic press_hit;
	logic signed [DELTA_W-1:0] q_signed;
	logic signed [REM_W-1:0] rem_signed;
	logic signed [AW-1:0] det_sum;
	logic signed [AW-1:0] sat_hi_ext;
	logic signed [AW-1:0] sat_lo_ext;
	logic signed [PW-1:0] det_next;
	logic [PW:0] push_sum;

	assign cmd_take = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || res.ready;
	assign cpd_eff = (cfg_cpd_q == '0) ? 8'd1 : cfg_cpd_q;
	assign div_dividend = sum_q[DELTA_W-1] ? DIV_W'(-sum_q) : sum_q[DIV_W-1:0];

	red_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(div_dividend),
		.divisor(cpd_eff),
		.sts(div_sts),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.ready = 1'b0;
		div_ctl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = (cmd_q == CMD_POLL && init_q) ? ST_WRAP : ST_DONE;
			end
			ST_WRAP: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_ctl.start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		raw_delta = $signed({2'b00, enc_q}) - $signed({2'b00, last_enc_q});
		mod_s = $signed({1'b0, cfg_mod_q});
		half_s = $signed({2'b00, cfg_mod_q[16:1]});
		if (dlt_q > half_s) begin
			wrapped = dlt_q - mod_s;
		end else if (dlt_q < -half_s) begin
			wrapped = dlt_q + mod_s;
		end else begin
			wrapped = dlt_q;
		end
		elapsed = now_q - last_tick_q;
		press_hit = (sw_q != last_sw_q) && (elapsed >= {16'b0, cfg_deb_q});

		q_signed = sum_q[DELTA_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		rem_signed = sum_q[DELTA_W-1] ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
		det_sum = AW'(det_q) + AW'(q_signed);
		sat_hi_ext = AW'(DET_SAT_MAX);
		sat_lo_ext = AW'(DET_SAT_MIN);
		if (det_sum > sat_hi_ext) begin
			det_next = DET_SAT_MAX;
		end else if (det_sum < sat_lo_ext) begin
			det_next = DET_SAT_MIN;
		end else begin
			det_next = det_sum[PW-1:0];
		end
		push_sum = {1'b0, pr_q} + (PW+1)'(back_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mod_q <= MODULUS_RESET;
			cfg_cpd_q <= CPD_RESET;
			cfg_deb_q <= DEBOUNCE_RESET;
			init_q <= 1'b0;
			last_enc_q <= '0;
			rem_q <= '0;
			det_q <= '0;
			last_sw_q <= '0;
			pr_q <= '0;
			last_tick_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_MODULUS: cfg_mod_q <= cfg.data;
					REG_CPD: cfg_cpd_q <= cfg.data[7:0];
					REG_DEBOUNCE: cfg_deb_q <= cfg.data[15:0];
					default: begin
					end
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_EXEC: begin
					case (cmd_q)
						CMD_POLL, CMD_INIT: begin
							if (cmd_q == CMD_INIT || !init_q) begin
								init_q <= 1'b1;
								last_enc_q <= enc_q;
								last_sw_q <= sw_q;
								last_tick_q <= now_q;
								rem_q <= '0;
								det_q <= '0;
								pr_q <= '0;
							end else begin
								last_enc_q <= enc_q;
							end
						end
						CMD_POP_DETENTS: begin
							if (det_q > DET_POP_HI) begin
								det_q <= det_q - DET_POP_HI;
							end else if (det_q < DET_POP_LO) begin
								det_q <= det_q - DET_POP_LO;
							end else begin
								det_q <= '0;
							end
						end
						CMD_POP_PRESSES: begin
							if (pr_q > PRESS_POP_MAX) begin
								pr_q <= pr_q - PRESS_POP_MAX;
							end else begin
								pr_q <= '0;
							end
						end
						CMD_PUSH_BACK: begin
							pr_q <= push_sum[PW] ? PRESS_SAT_MAX : push_sum[PW-1:0];
						end
						default: begin
						end
					endcase
				end
				ST_WRAP: begin
					if (press_hit) begin
						last_tick_q <= now_q;
						if (pr_q != PRESS_SAT_MAX) begin
							pr_q <= pr_q + 1'b1;
						end
					end
					last_sw_q <= sw_q;
				end
				ST_APPLY: begin
					det_q <= det_next;
					rem_q <= rem_signed;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd.command;
			enc_q <= cmd.encoder_count;
			sw_q <= cmd.switch_edge_count;
			now_q <= cmd.now_ticks;
			back_q <= cmd.pushback_amount;
		end
		case (state_q)
			ST_EXEC: begin
				dlt_q <= raw_delta;
				if (cmd_q == CMD_POP_DETENTS) begin
					if (det_q > DET_POP_HI) begin
						res_det_q <= 8'(POP_DET_MAX);
					end else if (det_q < DET_POP_LO) begin
						res_det_q <= 8'(POP_DET_MIN);
					end else begin
						res_det_q <= det_q[7:0];
					end
				end else begin
					res_det_q <= '0;
				end
				if (cmd_q == CMD_POP_PRESSES) begin
					res_pr_q <= (pr_q > PRESS_POP_MAX) ? 8'(POP_PRESS_MAX) : pr_q[7:0];
				end else begin
					res_pr_q <= '0;
				end
			end
			ST_WRAP: begin
				dlt_q <= wrapped;
			end
			ST_SUM: begin
				sum_q <= dlt_q + DELTA_W'(rem_q);
			end
			ST_DONE: begin
				if (out_free) begin
					out_det_q <= res_det_q;
					out_pr_q <= res_pr_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid = out_valid_q;
	assign res.detent_delta = out_det_q;
	assign res.press_count = out_pr_q;
	assign cfg.ready = 1'b1;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while a request is still in work");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res.valid && !res.ready |=> state_q == ST_DONE)
		else $error("result left the sequencer while the output was still full");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider started while busy");

endmodule
